// File: rtl/ftx_pkg.sv
`default_nettype none
package ftx_pkg;

    localparam int CLUSTER_BITS      = 28;
    localparam int MAX_EXTENTS_DEF   = 256;
    localparam int MAX_BACK_RUNS_DEF = 64;
    localparam int ARG_W             = 28;
    // signed width for free-gap arithmetic
    localparam int AW                = CLUSTER_BITS + 2;

    localparam logic [31:0] VAL_MEDIA = 32'h0fff_fff8;
    localparam logic [31:0] VAL_EOC   = 32'h0fff_ffff;
    localparam logic [31:0] VAL_BAD   = 32'h0fff_fff7;
    localparam logic [31:0] VAL_FREE  = 32'h0000_0000;
    localparam logic [31:0] RESERVED  = 32'd2;

    localparam logic [CLUSTER_BITS-1:0] DC_RESET = CLUSTER_BITS'(65536);
    localparam logic [CLUSTER_BITS-1:0] DC_MAX   = CLUSTER_BITS'((1 << CLUSTER_BITS) - 11);

    typedef enum logic [2:0] {
        OP_READ        = 3'd0,
        OP_WRITE       = 3'd1,
        OP_ALLOC_FRONT = 3'd2,
        OP_ALLOC_BACK  = 3'd3,
        OP_EXTEND      = 3'd4,
        OP_FINALIZE    = 3'd5
    } t_op;

    typedef struct packed {
        logic [CLUSTER_BITS-1:0] first;
        logic [CLUSTER_BITS-1:0] last;
        logic [31:0]             lit;
        logic [31:0]             nx;
        logic                    chain;
    } t_ext;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_SHIFT_UP,
        CMD_SHIFT_DOWN
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        t_ext    ext;
    } t_cmd;

    typedef struct packed {
        logic        search;
        logic [31:0] key;
    } t_query;

    typedef struct packed {
        logic found;
        t_ext ext;
    } t_pass;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FETCH,
        S_RD,
        S_WR_CHK,
        S_WR_PREV,
        S_WR_GROW,
        S_WR_RT,
        S_P_FIRST_WR,
        S_P_LAST_SH,
        S_P_SPLIT_SH2,
        S_P_SPLIT_TAIL,
        S_P_SPLIT_HEAD,
        S_P_NEW,
        S_AF,
        S_AB,
        S_EX_WALK,
        S_EX_END,
        S_EX_LINK,
        S_FN_CHK,
        S_FN_FREE,
        S_FN_BAD,
        S_FN_RD,
        S_FN_WR,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// File: rtl/ftx_cell.sv
`default_nettype none
module ftx_cell #(
    parameter int IDX_W = 8,
    parameter int CNT_W = 9
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [IDX_W-1:0]   i_cell_id,
    input  wire logic [CNT_W-1:0]   i_ext_cnt,
    input  wire ftx_pkg::t_query    i_query,
    input  wire logic [IDX_W-1:0]   i_query_idx,
    input  wire ftx_pkg::t_cmd      i_cmd,
    input  wire logic [IDX_W-1:0]   i_cmd_pos,
    input  wire ftx_pkg::t_ext      i_left,
    input  wire ftx_pkg::t_ext      i_right,
    output ftx_pkg::t_ext           o_ext,
    input  wire ftx_pkg::t_pass     i_pass,
    input  wire logic [IDX_W-1:0]   i_pass_k,
    output ftx_pkg::t_pass          o_pass,
    output logic [IDX_W-1:0]        o_pass_k
);

    ftx_pkg::t_ext  r_ext;
    ftx_pkg::t_ext  rst_ext;
    ftx_pkg::t_pass r_pass;
    logic [IDX_W-1:0] r_pass_k;
    logic in_use;
    logic hit;

    assign in_use = CNT_W'(i_cell_id) < i_ext_cnt;

    always_comb begin
        if (i_query.search) begin
            hit = in_use && (i_query.key >= 32'(r_ext.first))
                         && (i_query.key <= 32'(r_ext.last));
        end else begin
            hit = in_use && (i_query_idx == i_cell_id);
        end
    end

    always_comb begin
        rst_ext       = '0;
        rst_ext.first = (i_cell_id == IDX_W'(1)) ? ftx_pkg::CLUSTER_BITS'(1) : '0;
        rst_ext.last  = rst_ext.first;
        if (i_cell_id == '0) begin
            rst_ext.lit = ftx_pkg::VAL_MEDIA;
        end else if (i_cell_id == IDX_W'(1)) begin
            rst_ext.lit = ftx_pkg::VAL_EOC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext <= rst_ext;
        end else begin
            case (i_cmd.op)
                ftx_pkg::CMD_WRITE: begin
                    if (i_cmd_pos == i_cell_id) r_ext <= i_cmd.ext;
                end
                ftx_pkg::CMD_SHIFT_UP: begin
                    if (i_cell_id > i_cmd_pos) r_ext <= i_left;
                end
                ftx_pkg::CMD_SHIFT_DOWN: begin
                    if (i_cell_id >= i_cmd_pos) r_ext <= i_right;
                end
                default: ;
            endcase
        end
    end

    // hand the lookup result toward the far end of the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass.found <= 1'b0;
        end else begin
            r_pass.found <= hit | i_pass.found;
        end
        r_pass.ext <= hit ? r_ext : i_pass.ext;
        r_pass_k   <= hit ? i_cell_id : i_pass_k;
    end

    assign o_ext    = r_ext;
    assign o_pass   = r_pass;
    assign o_pass_k = r_pass_k;

endmodule
`default_nettype wire

// File: rtl/ftx_ctrl.sv
`default_nettype none
module ftx_ctrl #(
    parameter int MAX_EXTENTS   = ftx_pkg::MAX_EXTENTS_DEF,
    parameter int MAX_BACK_RUNS = ftx_pkg::MAX_BACK_RUNS_DEF,
    localparam int IW  = $clog2(MAX_EXTENTS),
    localparam int CW  = $clog2(MAX_EXTENTS + 1),
    localparam int BCW = $clog2(MAX_BACK_RUNS + 1),
    localparam int BAW = (MAX_BACK_RUNS > 1) ? $clog2(MAX_BACK_RUNS) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [2:0]                  i_operation,
    input  wire logic [ftx_pkg::ARG_W-1:0]   i_entry_index,
    input  wire logic [31:0]                 i_write_value,
    input  wire logic [ftx_pkg::ARG_W-1:0]   i_count,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [31:0]                      o_read_data,
    output logic                             o_error,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [ftx_pkg::ARG_W-1:0]   i_cfg_wr_data,
    output ftx_pkg::t_query                  o_query,
    output logic [IW-1:0]                    o_query_idx,
    output ftx_pkg::t_cmd                    o_cmd,
    output logic [IW-1:0]                    o_cmd_pos,
    output logic [CW-1:0]                    o_ext_cnt,
    input  wire ftx_pkg::t_pass              i_pass,
    input  wire logic [IW-1:0]               i_pass_k
);

    localparam int CB = ftx_pkg::CLUSTER_BITS;
    localparam int AW = ftx_pkg::AW;
    localparam logic signed [AW-1:0] ONE_S = AW'(1);

    ftx_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [CW-1:0]   r_wait, n_wait;
    logic [2:0]      r_op, n_op;
    logic [ftx_pkg::ARG_W-1:0] r_idx, n_idx, r_cnt_in, n_cnt_in;
    logic [31:0]     r_wv, n_wv;
    logic [CB-1:0]   r_dc;
    logic [CW-1:0]   r_ecnt, n_ecnt;
    logic [BCW-1:0]  r_bcnt, n_bcnt, r_bi, n_bi;
    logic [CB-1:0]   r_btop, n_btop;
    logic            r_ffound, n_ffound;
    ftx_pkg::t_ext   r_fext, n_fext, r_cur, n_cur;
    logic [IW-1:0]   r_fk, n_fk, r_k, n_k, r_pk, n_pk;
    logic [CW-1:0]   r_steps, n_steps;
    logic [31:0]     r_data, n_data;
    logic            r_err, n_err;
    ftx_pkg::t_query r_q, n_q;
    logic [IW-1:0]   r_qidx, n_qidx;
    logic signed [AW-1:0] r_fn_first, n_fn_first, r_fn_end, n_fn_end, r_fn_last, n_fn_last;
    logic            r_out_valid;
    logic [31:0]     r_out_data;
    logic            r_out_err;
    logic            out_load;

    logic [2*CB-1:0] r_mem [MAX_BACK_RUNS];
    logic [2*CB-1:0] r_mem_q;
    logic            mem_we;
    logic [BAW-1:0]  mem_waddr, mem_raddr;
    logic [2*CB-1:0] mem_wdata;

    logic [31:0]     key32;
    logic [31:0]     orig;
    logic signed [AW-1:0] ff_s, bf_s, c_s, fend_raw, fend;
    logic [CW-1:0]   top_idx;
    logic            alloc_bad;
    logic            new_chain;
    ftx_pkg::t_ext   new_ext;
    logic            rt_ok;
    int              fin_need;

    assign key32   = 32'(r_idx);
    assign top_idx = r_ecnt - CW'(1);

    always_comb begin
        if (!r_ffound) begin
            orig = ftx_pkg::VAL_BAD;
        end else if (!r_fext.chain) begin
            orig = r_fext.lit;
        end else if (key32 < 32'(r_fext.last)) begin
            orig = key32 + 32'd1;
        end else begin
            orig = r_fext.nx;
        end
    end

    always_comb begin
        ff_s      = $signed(AW'(r_fext.last)) + ONE_S;
        bf_s      = (r_bcnt == '0) ? $signed(AW'(r_dc)) + ONE_S : $signed(AW'(r_btop)) - ONE_S;
        c_s       = $signed(AW'(r_cnt_in));
        alloc_bad = (r_cnt_in == '0) || (c_s > bf_s - ff_s + ONE_S);
        fend_raw  = ff_s + c_s - ONE_S;
        fend      = (fend_raw > bf_s) ? bf_s : fend_raw;
        fin_need  = int'(r_bcnt) + int'(fend >= ff_s) + int'(bf_s >= fend + ONE_S);
    end

    always_comb begin
        new_chain     = !((r_wv == ftx_pkg::VAL_FREE) || (r_wv == ftx_pkg::VAL_BAD));
        new_ext.first = CB'(r_idx);
        new_ext.last  = CB'(r_idx);
        new_ext.lit   = new_chain ? 32'd0 : r_wv;
        new_ext.nx    = new_chain ? r_wv : 32'd0;
        new_ext.chain = new_chain;
        rt_ok = (r_k >= IW'(2)) && r_cur.chain &&
                ((r_wv == ftx_pkg::VAL_EOC) ||
                 ((r_wv >= ftx_pkg::RESERVED) && (r_wv < 32'(r_dc) + ftx_pkg::RESERVED)));
    end

    always_comb begin
        ftx_pkg::t_ext e_tmp;
        e_tmp      = r_cur;
        n_state    = r_state;
        n_ret      = r_ret;
        n_wait     = r_wait;
        n_op       = r_op;
        n_idx      = r_idx;
        n_wv       = r_wv;
        n_cnt_in   = r_cnt_in;
        n_ecnt     = r_ecnt;
        n_bcnt     = r_bcnt;
        n_bi       = r_bi;
        n_btop     = r_btop;
        n_ffound   = r_ffound;
        n_fext     = r_fext;
        n_fk       = r_fk;
        n_cur      = r_cur;
        n_k        = r_k;
        n_pk       = r_pk;
        n_steps    = r_steps;
        n_data     = r_data;
        n_err      = r_err;
        n_q        = r_q;
        n_qidx     = r_qidx;
        n_fn_first = r_fn_first;
        n_fn_end   = r_fn_end;
        n_fn_last  = r_fn_last;
        o_cmd      = '0;
        o_cmd.op   = ftx_pkg::CMD_NONE;
        o_cmd_pos  = '0;
        mem_we     = 1'b0;
        mem_waddr  = r_bcnt[BAW-1:0];
        mem_wdata  = '0;
        mem_raddr  = '0;
        out_load   = 1'b0;

        unique case (r_state)
            ftx_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_operation;
                    n_idx    = i_entry_index;
                    n_wv     = i_write_value;
                    n_cnt_in = i_count;
                    n_data   = '0;
                    n_err    = 1'b0;
                    n_steps  = '0;
                    n_wait   = '0;
                    n_q.key  = 32'(i_entry_index);
                    n_qidx   = top_idx[IW-1:0];
                    case (i_operation)
                        ftx_pkg::OP_READ: begin
                            n_q.search = 1'b1;
                            n_ret      = ftx_pkg::S_RD;
                            n_state    = ftx_pkg::S_FETCH;
                        end
                        ftx_pkg::OP_WRITE: begin
                            n_q.search = 1'b1;
                            n_ret      = ftx_pkg::S_WR_CHK;
                            n_state    = ftx_pkg::S_FETCH;
                        end
                        ftx_pkg::OP_EXTEND: begin
                            n_q.search = 1'b1;
                            n_ret      = ftx_pkg::S_EX_WALK;
                            n_state    = ftx_pkg::S_FETCH;
                        end
                        ftx_pkg::OP_ALLOC_FRONT: begin
                            n_q.search = 1'b0;
                            n_ret      = ftx_pkg::S_AF;
                            n_state    = ftx_pkg::S_FETCH;
                        end
                        ftx_pkg::OP_ALLOC_BACK: begin
                            n_q.search = 1'b0;
                            n_ret      = ftx_pkg::S_AB;
                            n_state    = ftx_pkg::S_FETCH;
                        end
                        ftx_pkg::OP_FINALIZE: begin
                            n_q.search = 1'b0;
                            n_ret      = ftx_pkg::S_FN_CHK;
                            n_state    = ftx_pkg::S_FETCH;
                        end
                        default: n_state = ftx_pkg::S_DONE;
                    endcase
                end
            end
            ftx_pkg::S_FETCH: begin
                // the answer reaches the row end through the pass register of every cell
                if (r_wait == CW'(MAX_EXTENTS)) begin
                    n_ffound = i_pass.found;
                    n_fext   = i_pass.ext;
                    n_fk     = i_pass_k;
                    n_state  = r_ret;
                end else begin
                    n_wait = r_wait + CW'(1);
                end
            end
            ftx_pkg::S_RD: begin
                n_data  = orig;
                n_state = ftx_pkg::S_DONE;
            end
            ftx_pkg::S_WR_CHK: begin
                n_state = ftx_pkg::S_DONE;
                if (r_wv == orig) begin
                    n_err = 1'b0;
                end else if ((key32 < ftx_pkg::RESERVED) || (orig == ftx_pkg::VAL_BAD)) begin
                    n_err = 1'b1;
                end else begin
                    n_k   = r_fk;
                    n_cur = r_fext;
                    if (32'(r_fext.first) == key32) begin
                        n_q.search = 1'b0;
                        n_qidx     = r_fk - IW'(1);
                        n_wait     = '0;
                        n_ret      = ftx_pkg::S_WR_PREV;
                        n_state    = ftx_pkg::S_FETCH;
                    end else begin
                        n_state = ftx_pkg::S_WR_RT;
                    end
                end
            end
            ftx_pkg::S_WR_PREV: begin
                if (!r_fext.chain ? (r_fext.lit == r_wv)
                                  : (r_fext.nx == 32'(r_fext.last) + 32'd1)) begin
                    e_tmp      = r_fext;
                    e_tmp.last = r_fext.last + CB'(1);
                    if (r_fext.chain) e_tmp.nx = r_wv;
                    o_cmd.op   = ftx_pkg::CMD_WRITE;
                    o_cmd.ext  = e_tmp;
                    o_cmd_pos  = r_k - IW'(1);
                    n_state    = ftx_pkg::S_WR_GROW;
                end else begin
                    n_state = ftx_pkg::S_WR_RT;
                end
            end
            ftx_pkg::S_WR_GROW: begin
                o_cmd_pos = r_k;
                if (r_cur.first == r_cur.last) begin
                    o_cmd.op = ftx_pkg::CMD_SHIFT_DOWN;
                    n_ecnt   = r_ecnt - CW'(1);
                end else begin
                    e_tmp.first = r_cur.first + CB'(1);
                    o_cmd.op    = ftx_pkg::CMD_WRITE;
                    o_cmd.ext   = e_tmp;
                end
                n_state = ftx_pkg::S_DONE;
            end
            ftx_pkg::S_WR_RT: begin
                n_state = ftx_pkg::S_DONE;
                if ((32'(r_cur.last) == key32) && rt_ok) begin
                    e_tmp.nx  = r_wv;
                    o_cmd.op  = ftx_pkg::CMD_WRITE;
                    o_cmd.ext = e_tmp;
                    o_cmd_pos = r_k;
                end else if (r_cur.first == r_cur.last) begin
                    o_cmd.op  = ftx_pkg::CMD_WRITE;
                    o_cmd.ext = new_ext;
                    o_cmd_pos = r_k;
                end else if (32'(r_cur.first) == key32) begin
                    if ({1'b0, r_ecnt} + (CW+1)'(1) > (CW+1)'(MAX_EXTENTS)) begin
                        n_err = 1'b1;
                    end else begin
                        o_cmd.op  = ftx_pkg::CMD_SHIFT_UP;
                        o_cmd_pos = r_k;
                        n_ecnt    = r_ecnt + CW'(1);
                        n_state   = ftx_pkg::S_P_FIRST_WR;
                    end
                end else if (32'(r_cur.last) == key32) begin
                    if ({1'b0, r_ecnt} + (CW+1)'(1) > (CW+1)'(MAX_EXTENTS)) begin
                        n_err = 1'b1;
                    end else begin
                        e_tmp.last = r_cur.last - CB'(1);
                        if (r_cur.chain) e_tmp.nx = key32;
                        o_cmd.op   = ftx_pkg::CMD_WRITE;
                        o_cmd.ext  = e_tmp;
                        o_cmd_pos  = r_k;
                        n_state    = ftx_pkg::S_P_LAST_SH;
                    end
                end else begin
                    if ({1'b0, r_ecnt} + (CW+1)'(2) > (CW+1)'(MAX_EXTENTS)) begin
                        n_err = 1'b1;
                    end else begin
                        o_cmd.op  = ftx_pkg::CMD_SHIFT_UP;
                        o_cmd_pos = r_k + IW'(1);
                        n_ecnt    = r_ecnt + CW'(1);
                        n_state   = ftx_pkg::S_P_SPLIT_SH2;
                    end
                end
            end
            ftx_pkg::S_P_FIRST_WR: begin
                e_tmp.first = r_cur.first + CB'(1);
                o_cmd.op    = ftx_pkg::CMD_WRITE;
                o_cmd.ext   = e_tmp;
                o_cmd_pos   = r_k + IW'(1);
                n_pk        = r_k;
                n_state     = ftx_pkg::S_P_NEW;
            end
            ftx_pkg::S_P_LAST_SH: begin
                o_cmd.op  = ftx_pkg::CMD_SHIFT_UP;
                o_cmd_pos = r_k + IW'(1);
                n_ecnt    = r_ecnt + CW'(1);
                n_pk      = r_k + IW'(1);
                n_state   = ftx_pkg::S_P_NEW;
            end
            ftx_pkg::S_P_SPLIT_SH2: begin
                o_cmd.op  = ftx_pkg::CMD_SHIFT_UP;
                o_cmd_pos = r_k + IW'(1);
                n_ecnt    = r_ecnt + CW'(1);
                n_state   = ftx_pkg::S_P_SPLIT_TAIL;
            end
            ftx_pkg::S_P_SPLIT_TAIL: begin
                e_tmp.first = CB'(r_idx) + CB'(1);
                o_cmd.op    = ftx_pkg::CMD_WRITE;
                o_cmd.ext   = e_tmp;
                o_cmd_pos   = r_k + IW'(2);
                n_state     = ftx_pkg::S_P_SPLIT_HEAD;
            end
            ftx_pkg::S_P_SPLIT_HEAD: begin
                e_tmp.last = CB'(r_idx) - CB'(1);
                if (r_cur.chain) e_tmp.nx = key32;
                o_cmd.op   = ftx_pkg::CMD_WRITE;
                o_cmd.ext  = e_tmp;
                o_cmd_pos  = r_k;
                n_pk       = r_k + IW'(1);
                n_state    = ftx_pkg::S_P_NEW;
            end
            ftx_pkg::S_P_NEW: begin
                o_cmd.op  = ftx_pkg::CMD_WRITE;
                o_cmd.ext = new_ext;
                o_cmd_pos = r_pk;
                n_state   = ftx_pkg::S_DONE;
            end
            ftx_pkg::S_AF: begin
                n_state = ftx_pkg::S_DONE;
                if (alloc_bad || (r_ecnt >= CW'(MAX_EXTENTS))) begin
                    n_err = 1'b1;
                end else begin
                    e_tmp.first = CB'(ff_s);
                    e_tmp.last  = CB'(fend_raw);
                    e_tmp.lit   = '0;
                    e_tmp.nx    = ftx_pkg::VAL_EOC;
                    e_tmp.chain = 1'b1;
                    o_cmd.op    = ftx_pkg::CMD_WRITE;
                    o_cmd.ext   = e_tmp;
                    o_cmd_pos   = r_ecnt[IW-1:0];
                    n_ecnt      = r_ecnt + CW'(1);
                    n_data      = 32'(CB'(ff_s));
                end
            end
            ftx_pkg::S_AB: begin
                n_state = ftx_pkg::S_DONE;
                if (alloc_bad || (r_bcnt >= BCW'(MAX_BACK_RUNS))) begin
                    n_err = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = {CB'(bf_s - c_s + ONE_S), CB'(bf_s)};
                    n_bcnt    = r_bcnt + BCW'(1);
                    n_btop    = CB'(bf_s - c_s + ONE_S);
                    n_data    = 32'(CB'(bf_s - c_s + ONE_S));
                end
            end
            ftx_pkg::S_EX_WALK: begin
                if (!r_ffound) begin
                    n_state = ftx_pkg::S_DONE;
                end else if (r_fext.nx == ftx_pkg::VAL_EOC) begin
                    n_k        = r_fk;
                    n_cur      = r_fext;
                    n_q.search = 1'b0;
                    n_qidx     = top_idx[IW-1:0];
                    n_wait     = '0;
                    n_ret      = ftx_pkg::S_EX_END;
                    n_state    = ftx_pkg::S_FETCH;
                end else if (!r_fext.chain || (r_steps >= CW'(MAX_EXTENTS))) begin
                    n_state = ftx_pkg::S_DONE;
                end else begin
                    n_steps    = r_steps + CW'(1);
                    n_q.search = 1'b1;
                    n_q.key    = r_fext.nx;
                    n_wait     = '0;
                    n_ret      = ftx_pkg::S_EX_WALK;
                    n_state    = ftx_pkg::S_FETCH;
                end
            end
            ftx_pkg::S_EX_END: begin
                n_state = ftx_pkg::S_DONE;
                if (ff_s > bf_s) begin
                    n_err = 1'b1;
                end else if (r_k == top_idx[IW-1:0]) begin
                    e_tmp.last = r_cur.last + CB'(1);
                    o_cmd.op   = ftx_pkg::CMD_WRITE;
                    o_cmd.ext  = e_tmp;
                    o_cmd_pos  = r_k;
                    n_data     = 32'(r_cur.last) + 32'd1;
                end else if (r_ecnt >= CW'(MAX_EXTENTS)) begin
                    n_err = 1'b1;
                end else begin
                    e_tmp.first = CB'(ff_s);
                    e_tmp.last  = CB'(ff_s);
                    e_tmp.nx    = ftx_pkg::VAL_EOC;
                    o_cmd.op    = ftx_pkg::CMD_WRITE;
                    o_cmd.ext   = e_tmp;
                    o_cmd_pos   = r_ecnt[IW-1:0];
                    n_ecnt      = r_ecnt + CW'(1);
                    n_data      = 32'(CB'(ff_s));
                    n_state     = ftx_pkg::S_EX_LINK;
                end
            end
            ftx_pkg::S_EX_LINK: begin
                e_tmp.nx  = r_data;
                o_cmd.op  = ftx_pkg::CMD_WRITE;
                o_cmd.ext = e_tmp;
                o_cmd_pos = r_k;
                n_state   = ftx_pkg::S_DONE;
            end
            ftx_pkg::S_FN_CHK: begin
                if (int'(r_ecnt) + fin_need > MAX_EXTENTS) begin
                    n_err   = 1'b1;
                    n_state = ftx_pkg::S_DONE;
                end else begin
                    n_fn_first = ff_s;
                    n_fn_end   = fend;
                    n_fn_last  = bf_s;
                    n_state    = ftx_pkg::S_FN_FREE;
                end
            end
            ftx_pkg::S_FN_FREE: begin
                if (r_fn_end >= r_fn_first) begin
                    e_tmp.first = CB'(r_fn_first);
                    e_tmp.last  = CB'(r_fn_end);
                    e_tmp.lit   = ftx_pkg::VAL_FREE;
                    e_tmp.nx    = ftx_pkg::VAL_FREE;
                    e_tmp.chain = 1'b0;
                    o_cmd.op    = ftx_pkg::CMD_WRITE;
                    o_cmd.ext   = e_tmp;
                    o_cmd_pos   = r_ecnt[IW-1:0];
                    n_ecnt      = r_ecnt + CW'(1);
                end
                n_state = ftx_pkg::S_FN_BAD;
            end
            ftx_pkg::S_FN_BAD: begin
                if (r_fn_last >= r_fn_end + ONE_S) begin
                    e_tmp.first = CB'(r_fn_end + ONE_S);
                    e_tmp.last  = CB'(r_fn_last);
                    e_tmp.lit   = ftx_pkg::VAL_BAD;
                    e_tmp.nx    = ftx_pkg::VAL_BAD;
                    e_tmp.chain = 1'b0;
                    o_cmd.op    = ftx_pkg::CMD_WRITE;
                    o_cmd.ext   = e_tmp;
                    o_cmd_pos   = r_ecnt[IW-1:0];
                    n_ecnt      = r_ecnt + CW'(1);
                end
                n_bi    = r_bcnt;
                n_state = ftx_pkg::S_FN_RD;
            end
            ftx_pkg::S_FN_RD: begin
                // back runs go in newest first
                if (r_bi == '0) begin
                    n_bcnt  = '0;
                    n_state = ftx_pkg::S_DONE;
                end else begin
                    mem_raddr = BAW'(r_bi - BCW'(1));
                    n_state   = ftx_pkg::S_FN_WR;
                end
            end
            ftx_pkg::S_FN_WR: begin
                e_tmp.first = r_mem_q[2*CB-1:CB];
                e_tmp.last  = r_mem_q[CB-1:0];
                e_tmp.lit   = '0;
                e_tmp.nx    = ftx_pkg::VAL_EOC;
                e_tmp.chain = 1'b1;
                o_cmd.op    = ftx_pkg::CMD_WRITE;
                o_cmd.ext   = e_tmp;
                o_cmd_pos   = r_ecnt[IW-1:0];
                n_ecnt      = r_ecnt + CW'(1);
                n_bi        = r_bi - BCW'(1);
                n_state     = ftx_pkg::S_FN_RD;
            end
            ftx_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ftx_pkg::S_IDLE;
                end
            end
            default: n_state = ftx_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ftx_pkg::S_IDLE;
            r_ret       <= ftx_pkg::S_IDLE;
            r_wait      <= '0;
            r_ecnt      <= CW'(2);
            r_bcnt      <= '0;
            r_bi        <= '0;
            r_steps     <= '0;
            r_ffound    <= 1'b0;
            r_out_valid <= 1'b0;
            r_dc        <= ftx_pkg::DC_RESET;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_wait   <= n_wait;
            r_ecnt   <= n_ecnt;
            r_bcnt   <= n_bcnt;
            r_bi     <= n_bi;
            r_steps  <= n_steps;
            r_ffound <= n_ffound;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_dc <= (i_cfg_wr_data > ftx_pkg::ARG_W'(ftx_pkg::DC_MAX)) ?
                        ftx_pkg::DC_MAX : CB'(i_cfg_wr_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_idx      <= n_idx;
        r_wv       <= n_wv;
        r_cnt_in   <= n_cnt_in;
        r_btop     <= n_btop;
        r_fext     <= n_fext;
        r_fk       <= n_fk;
        r_cur      <= n_cur;
        r_k        <= n_k;
        r_pk       <= n_pk;
        r_data     <= n_data;
        r_err      <= n_err;
        r_q        <= n_q;
        r_qidx     <= n_qidx;
        r_fn_first <= n_fn_first;
        r_fn_end   <= n_fn_end;
        r_fn_last  <= n_fn_last;
        if (out_load) begin
            r_out_data <= (r_op == ftx_pkg::OP_READ || r_op == ftx_pkg::OP_WRITE ||
                           r_op == ftx_pkg::OP_ALLOC_FRONT || r_op == ftx_pkg::OP_ALLOC_BACK ||
                           r_op == ftx_pkg::OP_EXTEND || r_op == ftx_pkg::OP_FINALIZE) ?
                          r_data : 32'd0;
            r_out_err  <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_mem_q <= r_mem[mem_raddr];
    end

    assign o_in_stall  = (r_state != ftx_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_error     = r_out_err;
    assign o_query     = r_q;
    assign o_query_idx = r_qidx;
    assign o_ext_cnt   = r_ecnt;

endmodule
`default_nettype wire

// File: rtl/fat_extent_table_engine.sv
// FAT extent table engine.
// Input channel: i_in_valid / o_in_stall carries operation, entry_index,
// write_value and count; a transfer happens when valid is high and stall low.
// Output channel: o_out_valid / i_out_stall carries read_data and error, one
// result per input item, in order. The data cluster count is written through
// i_cfg_wr_en / i_cfg_wr_data by the user only while idle; the block doesn't check.
// The extent table is a row of MAX_EXTENTS cells; a lookup is broadcast to
// all cells and the match is handed cell to cell. Inserts and removals
// shift the row. One item is in work at a time; the next can be taken in
// the cycle after the previous result is loaded.
// Reset (synchronous, active low) restores the two reserved extents, empties
// the back-run list and sets the data cluster count to 65536.
// While the receiver stalls, the finished result is held in the output
// register; one further item may be accepted and worked on meanwhile, and
// its result waits until the register frees.
`default_nettype none
module fat_extent_table_engine #(
    parameter int MAX_EXTENTS   = ftx_pkg::MAX_EXTENTS_DEF,
    parameter int MAX_BACK_RUNS = ftx_pkg::MAX_BACK_RUNS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [2:0]                i_operation,
    input  wire logic [ftx_pkg::ARG_W-1:0] i_entry_index,
    input  wire logic [31:0]               i_write_value,
    input  wire logic [ftx_pkg::ARG_W-1:0] i_count,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [31:0]                    o_read_data,
    output logic                           o_error,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [ftx_pkg::ARG_W-1:0] i_cfg_wr_data
);

    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);

    ftx_pkg::t_query w_query;
    logic [IW-1:0]   w_query_idx;
    ftx_pkg::t_cmd   w_cmd;
    logic [IW-1:0]   w_cmd_pos;
    logic [CW-1:0]   w_ext_cnt;
    ftx_pkg::t_ext   w_ext  [MAX_EXTENTS];
    ftx_pkg::t_pass  w_pass [MAX_EXTENTS+1];
    logic [IW-1:0]   w_pass_k [MAX_EXTENTS+1];

    assign w_pass[0]   = '0;
    assign w_pass_k[0] = '0;

    ftx_ctrl #(
        .MAX_EXTENTS   (MAX_EXTENTS),
        .MAX_BACK_RUNS (MAX_BACK_RUNS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_write_value (i_write_value),
        .i_count       (i_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_data   (o_read_data),
        .o_error       (o_error),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_query       (w_query),
        .o_query_idx   (w_query_idx),
        .o_cmd         (w_cmd),
        .o_cmd_pos     (w_cmd_pos),
        .o_ext_cnt     (w_ext_cnt),
        .i_pass        (w_pass[MAX_EXTENTS]),
        .i_pass_k      (w_pass_k[MAX_EXTENTS])
    );

    for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
        ftx_pkg::t_ext w_left;
        ftx_pkg::t_ext w_right;
        if (g == 0) begin : g_lo
            assign w_left = w_ext[g];
        end else begin : g_lo
            assign w_left = w_ext[g-1];
        end
        if (g == MAX_EXTENTS - 1) begin : g_hi
            assign w_right = w_ext[g];
        end else begin : g_hi
            assign w_right = w_ext[g+1];
        end
        ftx_cell #(
            .IDX_W (IW),
            .CNT_W (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cell_id   (IW'(g)),
            .i_ext_cnt   (w_ext_cnt),
            .i_query     (w_query),
            .i_query_idx (w_query_idx),
            .i_cmd       (w_cmd),
            .i_cmd_pos   (w_cmd_pos),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_ext       (w_ext[g]),
            .i_pass      (w_pass[g]),
            .i_pass_k    (w_pass_k[g]),
            .o_pass      (w_pass[g+1]),
            .o_pass_k    (w_pass_k[g+1])
        );
    end

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;

    localparam int TBL_DEPTH   = ftx_pkg::MAX_EXTENTS_DEF;
    localparam int RUNS_DEPTH  = ftx_pkg::MAX_BACK_RUNS_DEF;
    localparam int CYCLE_LIMIT = 40_000_000;

    typedef struct {
        bit [31:0] first;
        bit [31:0] last;
        bit [31:0] lit;
        bit [31:0] nx;
        bit        chain;
    } t_extent;

    typedef struct {
        bit [31:0] data;
        bit        err;
    } t_fat_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  in_operation = '0;
    logic [27:0] in_entry_index = '0;
    logic [31:0] in_write_value = '0;
    logic [27:0] in_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] out_read_data;
    logic        out_error;
    logic        cfg_wr_en = 1'b0;
    logic [27:0] cfg_wr_data = '0;

    // shadow copy of the table
    t_extent   tbl[TBL_DEPTH];
    int        ext_count;
    bit [31:0] back_first[RUNS_DEPTH];
    bit [31:0] back_last[RUNS_DEPTH];
    int        back_count;
    bit [31:0] clusters;

    t_fat_result pending_results[$];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          mismatches = 0;
    longint      cycles = 0;

    fat_extent_table_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_operation   (in_operation),
        .i_entry_index (in_entry_index),
        .i_write_value (in_write_value),
        .i_count       (in_count),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_read_data   (out_read_data),
        .o_error       (out_error),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_extent mk(bit [31:0] f, bit [31:0] l, bit [31:0] lit,
                                   bit [31:0] nx, bit ch);
        t_extent x;
        x.first = f;
        x.last = l;
        x.lit = lit;
        x.nx = nx;
        x.chain = ch;
        return x;
    endfunction

    function automatic int locate_extent(bit [31:0] c);
        int lo = 0;
        int hi = ext_count - 1;
        int m;
        while (lo <= hi) begin
            m = lo + (hi - lo) / 2;
            if (c < tbl[m].first) hi = m - 1;
            else if (c > tbl[m].last) lo = m + 1;
            else return m;
        end
        return -1;
    endfunction

    function automatic bit [31:0] entry_value(bit [31:0] c);
        int k = locate_extent(c);
        if (k < 0) return ftx_pkg::VAL_BAD;
        if (!tbl[k].chain) return tbl[k].lit;
        if (c < tbl[k].last) return c + 32'd1;
        return tbl[k].nx;
    endfunction

    function automatic longint front_gap();
        if (ext_count == 0) return 0;
        return longint'(tbl[ext_count-1].last) + 1;
    endfunction

    function automatic longint back_gap();
        if (back_count == 0) return longint'(clusters) + 1;
        return longint'(back_first[back_count-1]) - 1;
    endfunction

    function automatic void shift_up(int pos, int n);
        for (int i = ext_count - 1; i >= pos; i--) tbl[i+n] = tbl[i];
        ext_count += n;
    endfunction

    function automatic void shift_down(int pos);
        for (int i = pos; i < ext_count - 1; i++) tbl[i] = tbl[i+1];
        ext_count--;
    endfunction

    function automatic bit grow_prev(int p, bit [31:0] v);
        if (!tbl[p].chain) begin
            if (tbl[p].lit != v) return 0;
            tbl[p].last++;
            return 1;
        end
        if (tbl[p].nx != tbl[p].last + 32'd1) return 0;
        tbl[p].nx = v;
        tbl[p].last++;
        return 1;
    endfunction

    function automatic bit retarget(int k, bit [31:0] v);
        if (k < 2 || !tbl[k].chain) return 0;
        if (v == ftx_pkg::VAL_EOC || (v >= 2 && longint'(v) < longint'(clusters) + 2)) begin
            tbl[k].nx = v;
            return 1;
        end
        return 0;
    endfunction

    function automatic bit punch(int k, bit [31:0] e, bit [31:0] v);
        bit        ch = (v == ftx_pkg::VAL_FREE || v == ftx_pkg::VAL_BAD) ? 1'b0 : 1'b1;
        bit [31:0] lit = ch ? 32'd0 : v;
        bit [31:0] nx = ch ? v : 32'd0;
        if (tbl[k].first == tbl[k].last) begin
            tbl[k] = mk(e, e, lit, nx, ch);
            return 1;
        end
        if (tbl[k].first == e) begin
            if (ext_count + 1 > TBL_DEPTH) return 0;
            shift_up(k, 1);
            tbl[k+1].first++;
            tbl[k] = mk(e, e, lit, nx, ch);
            return 1;
        end
        if (tbl[k].last == e) begin
            if (ext_count + 1 > TBL_DEPTH) return 0;
            tbl[k].last--;
            if (tbl[k].chain) tbl[k].nx = e;
            shift_up(k + 1, 1);
            tbl[k+1] = mk(e, e, lit, nx, ch);
            return 1;
        end
        if (ext_count + 2 > TBL_DEPTH) return 0;
        shift_up(k + 1, 2);
        tbl[k+2] = mk(e + 32'd1, tbl[k].last, tbl[k].lit, tbl[k].nx, tbl[k].chain);
        tbl[k].last = e - 32'd1;
        if (tbl[k].chain) tbl[k].nx = e;
        tbl[k+1] = mk(e, e, lit, nx, ch);
        return 1;
    endfunction

    function automatic bit write_entry(bit [31:0] e, bit [31:0] v);
        bit [31:0] orig = entry_value(e);
        int k;
        if (v == orig) return 1;
        if (e < 2 || orig == ftx_pkg::VAL_BAD) return 0;
        k = locate_extent(e);
        if (k <= 0) return 0;
        if (tbl[k].first == e && grow_prev(k - 1, v)) begin
            if (tbl[k].first == tbl[k].last) shift_down(k);
            else tbl[k].first++;
            return 1;
        end
        if (tbl[k].last == e && retarget(k, v)) return 1;
        return punch(k, e, v);
    endfunction

    function automatic bit [31:0] extend_chain(bit [31:0] c, inout bit err);
        int        k = locate_extent(c);
        int        steps = 0;
        bit [31:0] start;
        while (k >= 0 && tbl[k].nx != ftx_pkg::VAL_EOC) begin
            if (!tbl[k].chain || steps >= TBL_DEPTH) return 32'd0;
            steps++;
            k = locate_extent(tbl[k].nx);
        end
        if (k < 0) return 32'd0;
        if (front_gap() > back_gap()) begin
            err = 1'b1;
            return 32'd0;
        end
        if (k == ext_count - 1) begin
            tbl[k].last++;
            return tbl[k].last;
        end
        if (ext_count >= TBL_DEPTH) begin
            err = 1'b1;
            return 32'd0;
        end
        start = 32'(front_gap());
        tbl[ext_count] = mk(start, start, tbl[k].lit, ftx_pkg::VAL_EOC, tbl[k].chain);
        ext_count++;
        tbl[k].nx = start;
        return start;
    endfunction

    function automatic bit finalize_table(bit [31:0] cap);
        longint lo = front_gap();
        longint hi = back_gap();
        longint fend = lo + longint'(cap) - 1;
        int     need = back_count;
        if (fend > hi) fend = hi;
        if (fend >= lo) need++;
        if (hi >= fend + 1) need++;
        if (ext_count + need > TBL_DEPTH) return 0;
        if (fend >= lo) begin
            tbl[ext_count] = mk(32'(lo), 32'(fend), ftx_pkg::VAL_FREE, ftx_pkg::VAL_FREE,
                                1'b0);
            ext_count++;
        end
        if (hi >= fend + 1) begin
            tbl[ext_count] = mk(32'(fend + 1), 32'(hi), ftx_pkg::VAL_BAD, ftx_pkg::VAL_BAD,
                                1'b0);
            ext_count++;
        end
        for (int i = back_count; i > 0; i--) begin
            tbl[ext_count] = mk(back_first[i-1], back_last[i-1], 32'd0, ftx_pkg::VAL_EOC,
                                1'b1);
            ext_count++;
        end
        back_count = 0;
        return 1;
    endfunction

    function automatic t_fat_result predict_fat_op(bit [2:0] op, bit [31:0] idx,
                                                  bit [31:0] wv, bit [31:0] cnt);
        t_fat_result r;
        longint lo = front_gap();
        longint hi = back_gap();
        r.data = '0;
        r.err = 1'b0;
        case (op)
            ftx_pkg::OP_READ:  r.data = entry_value(idx);
            ftx_pkg::OP_WRITE: r.err = !write_entry(idx, wv);
            ftx_pkg::OP_ALLOC_FRONT: begin
                if (cnt == 0 || longint'(cnt) > hi - lo + 1 || ext_count >= TBL_DEPTH) begin
                    r.err = 1'b1;
                end else begin
                    tbl[ext_count] = mk(32'(lo), 32'(lo + longint'(cnt) - 1), 32'd0,
                                        ftx_pkg::VAL_EOC, 1'b1);
                    ext_count++;
                    r.data = 32'(lo);
                end
            end
            ftx_pkg::OP_ALLOC_BACK: begin
                if (cnt == 0 || longint'(cnt) > hi - lo + 1 || back_count >= RUNS_DEPTH) begin
                    r.err = 1'b1;
                end else begin
                    back_first[back_count] = 32'(hi - longint'(cnt) + 1);
                    back_last[back_count] = 32'(hi);
                    back_count++;
                    r.data = 32'(hi - longint'(cnt) + 1);
                end
            end
            ftx_pkg::OP_EXTEND:   r.data = extend_chain(idx, r.err);
            ftx_pkg::OP_FINALIZE: r.err = !finalize_table(cnt);
            default: ;
        endcase
        return r;
    endfunction

    // hold the payload until the transfer, then maybe idle
    task automatic send_item(bit [2:0] op, bit [27:0] idx, bit [31:0] wv, bit [27:0] cnt);
        in_valid <= 1'b1;
        in_operation <= op;
        in_entry_index <= idx;
        in_write_value <= wv;
        in_count <= cnt;
        pending_results.insert(pending_results.size(),
                               predict_fat_op(op, 32'(idx), wv, 32'(cnt)));
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_clusters(bit [27:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        clusters = (v > ftx_pkg::DC_MAX) ? 32'(ftx_pkg::DC_MAX) : 32'(v);
    endtask

    function automatic bit [27:0] clip28(longint v);
        if (v < 0) return 28'd0;
        if (v > 28'hfffffff) return 28'hfffffff;
        return 28'(v);
    endfunction

    function automatic bit [27:0] pick_cluster();
        int r = int'($urandom_range(9));
        if (r < 6) return 28'($urandom_range(0, clip28(front_gap() + 3)));
        if (r < 8) return 28'($urandom_range(clip28(back_gap()),
                                             clip28(longint'(clusters) + 2)));
        return 28'($urandom);
    endfunction

    function automatic bit [31:0] pick_value(bit [27:0] idx);
        case ($urandom_range(7))
            0: return ftx_pkg::VAL_FREE;
            1: return ftx_pkg::VAL_BAD;
            2: return ftx_pkg::VAL_EOC;
            3: return 32'(idx) + 32'd1;
            4: return 32'($urandom_range(2, clip28(longint'(clusters) + 1)));
            5: return 32'($urandom);
            6: return entry_value(32'(idx));
            default: return 32'($urandom_range(0, clip28(front_gap() + 3)));
        endcase
    endfunction

    function automatic bit [27:0] pick_count();
        longint gap = back_gap() - front_gap() + 1;
        case ($urandom_range(9))
            0: return 28'd0;
            1: return 28'($urandom);
            2: return clip28(gap);
            3: return clip28(gap + 1);
            default: return 28'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic test_directed();
        send_item(ftx_pkg::OP_READ, 0, 0, 0);
        send_item(ftx_pkg::OP_READ, 1, 0, 0);
        send_item(ftx_pkg::OP_READ, 2, 0, 0);
        send_item(ftx_pkg::OP_WRITE, 0, 5, 0);
        send_item(ftx_pkg::OP_WRITE, 1, ftx_pkg::VAL_FREE, 0);
        send_item(ftx_pkg::OP_WRITE, 0, ftx_pkg::VAL_MEDIA, 0);
        send_item(ftx_pkg::OP_WRITE, 9, 3, 0);
        send_item(ftx_pkg::OP_ALLOC_FRONT, 0, 0, 0);
        send_item(ftx_pkg::OP_ALLOC_FRONT, 0, 0, 28'hfffffff);
        send_item(ftx_pkg::OP_ALLOC_FRONT, 0, 0, 6);
        send_item(ftx_pkg::OP_READ, 3, 0, 0);
        send_item(ftx_pkg::OP_READ, 7, 0, 0);
        send_item(ftx_pkg::OP_WRITE, 3, 4, 0);
        send_item(ftx_pkg::OP_WRITE, 4, 100, 0);
        send_item(ftx_pkg::OP_WRITE, 7, 9, 0);
        send_item(ftx_pkg::OP_WRITE, 5, ftx_pkg::VAL_BAD, 0);
        send_item(ftx_pkg::OP_WRITE, 5, 6, 0);
        send_item(ftx_pkg::OP_ALLOC_BACK, 0, 0, 3);
        send_item(ftx_pkg::OP_READ, 65535, 0, 0);
        send_item(ftx_pkg::OP_EXTEND, 2, 0, 0);
        send_item(ftx_pkg::OP_EXTEND, 1, 0, 0);
        send_item(ftx_pkg::OP_FINALIZE, 0, 32'hffffffff, 10);
        send_item(ftx_pkg::OP_READ, 65536, 0, 0);
        send_item(3'd6, 28'hfffffff, 32'hffffffff, 28'hfffffff);
        send_item(3'd7, 0, 0, 0);
    endtask

    task automatic test_random(int n);
        bit [2:0]  op;
        bit [27:0] idx;
        int        r;
        for (int i = 0; i < n; i++) begin
            r = int'($urandom_range(99));
            if (r < 30) op = ftx_pkg::OP_READ;
            else if (r < 66) op = ftx_pkg::OP_WRITE;
            else if (r < 76) op = ftx_pkg::OP_ALLOC_FRONT;
            else if (r < 86) op = ftx_pkg::OP_ALLOC_BACK;
            else if (r < 91) op = ftx_pkg::OP_EXTEND;
            else if (r < 93) op = ftx_pkg::OP_FINALIZE;
            else if (r < 95) op = 3'($urandom_range(6, 7));
            else op = ftx_pkg::OP_READ;
            idx = pick_cluster();
            send_item(op, idx, pick_value(idx),
                      (op == ftx_pkg::OP_FINALIZE && $urandom_range(1)) ?
                      28'($urandom_range(0, 20)) : pick_count());
        end
    endtask

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_fat_result want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: read_data=%h error=%b",
                             out_read_data, out_error);
            end else begin
                want = pending_results.pop_front();
                if (out_read_data !== want.data || out_error !== want.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected read_data=%h error=%b, got %h %b",
                                 want.data, want.err, out_read_data, out_error);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TBL_DEPTH; i++) tbl[i] = mk(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        tbl[0] = mk(32'd0, 32'd0, ftx_pkg::VAL_MEDIA, 32'd0, 1'b0);
        tbl[1] = mk(32'd1, 32'd1, ftx_pkg::VAL_EOC, 32'd0, 1'b0);
        ext_count = 2;
        back_count = 0;
        clusters = 32'(ftx_pkg::DC_RESET);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(500);

        set_clusters(28'hfffffff);
        send_idle_pct = 52;
        test_random(450);

        set_clusters(28'd1);
        send_idle_pct = 0;
        stall_pct = 52;
        test_random(300);

        set_clusters(28'd300);
        send_idle_pct = 30;
        stall_pct = 30;
        test_random(300);

        set_clusters(ftx_pkg::DC_RESET);
        send_idle_pct = 0;
        stall_pct = 0;
        test_random(275);

        drain();
        repeat (600) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
